/* hw/rtl/jcre_pkg.sv */
// ============================================================================
// jcre_pkg - shared types and constants for the coefficient run expander
// Command format between front and back, sequencer states, zigzag table.
// ============================================================================
package jcre_pkg;

    localparam int BLOCK_COEFFS = 64;
    localparam int ZZ_W         = $clog2(BLOCK_COEFFS);
    localparam logic [ZZ_W-1:0] LAST_ZZ = ZZ_W'(BLOCK_COEFFS - 1);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // input item kinds and component codes
    localparam logic       KIND_QWRITE = 1'b0;
    localparam logic       KIND_SYMBOL = 1'b1;
    localparam logic [1:0] COMP_Y      = 2'd0;
    localparam logic [1:0] COMP_UNUSED = 2'd3;

    typedef enum logic
    {
        OP_QWRITE,
        OP_EXPAND
    } op_t;

    // one queued command: table write, or a zero run plus optional value
    typedef struct packed
    {
        op_t               op;
        logic [6:0]        q_addr;
        logic [7:0]        q_data;
        logic [ZZ_W-1:0]   start;
        logic [ZZ_W-1:0]   nzeros;
        logic              has_val;
        logic signed [15:0] value;
        logic              tsel;
        logic              ovr;
    } cmd_t;

    typedef enum logic [1:0]
    {
        SEQ_IDLE,
        SEQ_ZEROS,
        SEQ_VALUE
    } seq_state_t;

    localparam logic [5:0] ZZ_NAT [0:63] = '{
        6'd0,  6'd1,  6'd8,  6'd16, 6'd9,  6'd2,  6'd3,  6'd10,
        6'd17, 6'd24, 6'd32, 6'd25, 6'd18, 6'd11, 6'd4,  6'd5,
        6'd12, 6'd19, 6'd26, 6'd33, 6'd40, 6'd48, 6'd41, 6'd34,
        6'd27, 6'd20, 6'd13, 6'd6,  6'd7,  6'd14, 6'd21, 6'd28,
        6'd35, 6'd42, 6'd49, 6'd56, 6'd57, 6'd50, 6'd43, 6'd36,
        6'd29, 6'd22, 6'd15, 6'd23, 6'd30, 6'd37, 6'd44, 6'd51,
        6'd58, 6'd59, 6'd52, 6'd45, 6'd38, 6'd31, 6'd39, 6'd46,
        6'd53, 6'd60, 6'd61, 6'd54, 6'd47, 6'd55, 6'd62, 6'd63
    };

    function automatic logic [5:0] zz_to_nat(input logic [ZZ_W-1:0] zz);
        return ZZ_NAT[zz];
    endfunction

endpackage

/* hw/rtl/jcre_front.sv */
// ============================================================================
// jcre_front - symbol classifier
// Tracks block position and DC predictors, turns each item into a command.
// ============================================================================
module jcre_front
    import jcre_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        kind,
    input  logic [1:0]  component,
    input  logic [7:0]  run_size,
    input  logic [10:0] extra_bits,
    input  logic        table_select,
    input  logic [5:0]  quant_pos,
    input  logic [7:0]  quant_value,
    input  logic        q_full,
    output logic        q_push,
    output cmd_t        q_cmd
);

    logic [ZZ_W-1:0] pos_reg, pos_next;
    logic [15:0]     pred_reg [3];
    logic            take;
    logic            symbol_ok;
    logic signed [11:0] mag;
    logic [15:0]     dc_sum;
    logic [3:0]      run;
    logic [ZZ_W:0]   end_sum;

    // sign-extend size bits of magnitude, size clamped to eleven
    function automatic logic signed [11:0] magnitude(input logic [3:0] size_in,
                                                     input logic [10:0] bits);
        logic [3:0]  s;
        logic [10:0] mask;
        logic [10:0] raw;
        logic signed [11:0] res;
        s    = (size_in > 4'd11) ? 4'd11 : size_in;
        mask = 11'((12'd1 << s) - 12'd1);
        raw  = bits & mask;
        if (s == 4'd0)
            res = '0;
        else if (!raw[s - 4'd1])
            res = $signed({1'b0, raw}) - $signed({1'b0, mask});
        else
            res = $signed({1'b0, raw});
        return res;
    endfunction

    assign in_stall  = q_full;
    assign take      = in_valid && !q_full;
    assign symbol_ok = (kind == KIND_SYMBOL) && (component != COMP_UNUSED);
    assign q_push    = take && ((kind == KIND_QWRITE) || symbol_ok);

    assign mag     = magnitude(run_size[3:0], extra_bits);
    assign dc_sum  = pred_reg[component] + 16'(mag);
    assign run     = run_size[7:4];
    assign end_sum = {1'b0, pos_reg} + (ZZ_W+1)'(run);

    // classify the item into a command
    always_comb
    begin
        q_cmd         = '0;
        q_cmd.op      = OP_EXPAND;
        q_cmd.q_addr  = {table_select, quant_pos};
        q_cmd.q_data  = quant_value;
        q_cmd.start   = pos_reg;
        q_cmd.tsel    = (component != COMP_Y);
        pos_next      = pos_reg;
        if (kind == KIND_QWRITE)
        begin
            q_cmd.op = OP_QWRITE;
        end
        else if (pos_reg == '0)
        begin
            // DC difference
            q_cmd.has_val = 1'b1;
            q_cmd.value   = $signed(dc_sum);
            pos_next      = ZZ_W'(1);
        end
        else if (run_size == 8'h00)
        begin
            // end of block
            q_cmd.nzeros = ZZ_W'(BLOCK_COEFFS - {1'b0, pos_reg});
            pos_next     = '0;
        end
        else if (end_sum[ZZ_W])
        begin
            // run passes block end: truncate
            q_cmd.nzeros = ZZ_W'(BLOCK_COEFFS - {1'b0, pos_reg});
            q_cmd.ovr    = 1'b1;
            pos_next     = '0;
        end
        else
        begin
            q_cmd.nzeros  = ZZ_W'(run);
            q_cmd.has_val = 1'b1;
            q_cmd.value   = 16'(mag);
            pos_next      = ZZ_W'(end_sum + 1'b1);
        end
    end

    // block position and predictors
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            for (int i = 0; i < 3; i++)
                pred_reg[i] <= '0;
        end
        else if (take && symbol_ok)
        begin
            pos_reg <= pos_next;
            if (pos_reg == '0)
                pred_reg[component] <= dc_sum;
        end
    end

endmodule

/* hw/rtl/jcre_queue.sv */
// ============================================================================
// jcre_queue - command queue
// Small FIFO that decouples the classifier from the expander.
// ============================================================================
module jcre_queue
    import jcre_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output cmd_t head,
    output logic empty
);

    cmd_t              entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;

    assign full  = (count_reg == (QPTR_W+1)'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = entry_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

endmodule

/* hw/rtl/jcre_back.sv */
// ============================================================================
// jcre_back - run expander and dequantizer
// Sequences zero runs and values, reads the quantization table, multiplies.
// ============================================================================
module jcre_back
    import jcre_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  cmd_t        head,
    input  logic        q_empty,
    output logic        q_pop,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [23:0] coefficient,
    output logic [2:0]  row,
    output logic [2:0]  col,
    output logic        block_last,
    output logic        overrun
);

    seq_state_t      state_reg, state_next;
    logic [ZZ_W-1:0] zz_reg, zz_next;
    logic [ZZ_W-1:0] left_reg, left_next;
    cmd_t            cur_reg, cur_next;
    logic            adv;
    logic            wr_en;
    logic            iss_valid;
    logic            iss_zero;
    logic            iss_read;

    logic [7:0]      qmem [128];
    logic [7:0]      q_rd_reg;

    logic            s1_valid_reg;
    logic [ZZ_W-1:0] s1_zz_reg;
    logic signed [15:0] s1_val_reg;
    logic            s1_zero_reg;
    logic            s1_ovr_reg;

    logic            out_valid_reg;
    logic [23:0]     coefficient_reg;
    logic [2:0]      row_reg;
    logic [2:0]      col_reg;
    logic            last_reg;
    logic            ovr_reg;

    logic signed [24:0] prod;
    logic [5:0]      nat;

    // whole pipeline moves when the output register is free
    assign adv = !out_valid_reg || !out_stall;

    // sequencer: next state and issue
    always_comb
    begin
        state_next = state_reg;
        zz_next    = zz_reg;
        left_next  = left_reg;
        cur_next   = cur_reg;
        q_pop      = 1'b0;
        wr_en      = 1'b0;
        iss_valid  = 1'b0;
        iss_zero   = 1'b1;
        iss_read   = 1'b0;
        case (state_reg)
            SEQ_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop = 1'b1;
                    if (head.op == OP_QWRITE)
                        wr_en = 1'b1;
                    else
                    begin
                        cur_next   = head;
                        zz_next    = head.start;
                        left_next  = head.nzeros;
                        state_next = (head.nzeros != '0) ? SEQ_ZEROS : SEQ_VALUE;
                    end
                end
            end
            SEQ_ZEROS:
            begin
                iss_valid = 1'b1;
                if (adv)
                begin
                    zz_next   = zz_reg + 1'b1;
                    left_next = left_reg - 1'b1;
                    if (left_reg == ZZ_W'(1))
                        state_next = cur_reg.has_val ? SEQ_VALUE : SEQ_IDLE;
                end
            end
            SEQ_VALUE:
            begin
                iss_valid = 1'b1;
                iss_zero  = (cur_reg.value == '0);
                iss_read  = adv;
                if (adv)
                    state_next = SEQ_IDLE;
            end
            default:
            begin
                state_next = SEQ_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SEQ_IDLE;
            zz_reg    <= '0;
            left_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            zz_reg    <= zz_next;
            left_reg  <= left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

    // quantization table
    always_ff @(posedge clk)
    begin
        if (wr_en)
            qmem[head.q_addr] <= head.q_data;
        if (iss_read)
            q_rd_reg <= qmem[{cur_reg.tsel, zz_reg}];
    end

    // stage 1: issued coefficient
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (adv)
            s1_valid_reg <= iss_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_zz_reg   <= zz_reg;
            s1_val_reg  <= cur_reg.value;
            s1_zero_reg <= iss_zero;
            s1_ovr_reg  <= cur_reg.ovr;
        end
    end

    // stage 2: dequantize into the output register
    assign prod = s1_val_reg * $signed({1'b0, q_rd_reg});
    assign nat  = zz_to_nat(s1_zz_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv)
            out_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv && s1_valid_reg)
        begin
            coefficient_reg <= s1_zero_reg ? 24'd0 : prod[23:0];
            row_reg         <= nat[5:3];
            col_reg         <= nat[2:0];
            last_reg        <= (s1_zz_reg == LAST_ZZ);
            ovr_reg         <= s1_ovr_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign coefficient = coefficient_reg;
    assign row         = row_reg;
    assign col         = col_reg;
    assign block_last  = last_reg;
    assign overrun     = ovr_reg;

    // a zero run never starts empty
    a_run_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == SEQ_ZEROS) |-> (left_reg != '0))
        else $error("zero run with nothing left");

    // a run reaching the last position must end there
    a_run_ends_at_block_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == SEQ_ZEROS && zz_reg == LAST_ZZ) |-> (left_reg == ZZ_W'(1)))
        else $error("zero run crosses block end");

    // value state only for commands that carry a value
    a_value_has_val: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == SEQ_VALUE) |-> cur_reg.has_val)
        else $error("value issued for a run-only command");

    // a stalled output freezes stage 1
    a_stall_holds_s1: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> ($stable(s1_zz_reg) && $stable(s1_valid_reg)))
        else $error("stage 1 moved under stall");

endmodule

/* hw/rtl/jpeg_coefficient_run_expander.sv */
// ============================================================================
// jpeg_coefficient_run_expander - baseline coefficient decode
// Sign-extends magnitudes, applies DC prediction, expands zero runs and
// dequantizes; one coefficient per transfer with natural row and column.
// ============================================================================
// Path: input item, command queue, sequencer, stage 1, output register.
// Flow: the expander pops a command only when idle; a table write is done at
//   the pop, and runs issue one coefficient per cycle while the output is not
//   stalled; a 4-entry command queue lets the input keep accepting while a long run is expanded.
// Reset: asynchronous, clears DC predictors, block position, queue and
//   pipeline; the quantization table is not cleared and must be written first.
module jpeg_coefficient_run_expander
    import jcre_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        kind,
    input  logic [1:0]  component,
    input  logic [7:0]  run_size,
    input  logic [10:0] extra_bits,
    input  logic        table_select,
    input  logic [5:0]  quant_pos,
    input  logic [7:0]  quant_value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic signed [23:0] coefficient,
    output logic [2:0]  row,
    output logic [2:0]  col,
    output logic        block_last,
    output logic        overrun
);

    cmd_t push_cmd;
    cmd_t head;
    logic q_push;
    logic q_full;
    logic q_pop;
    logic q_empty;
    logic [23:0] coef_bits;

    jcre_front u_front
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .component    (component),
        .run_size     (run_size),
        .extra_bits   (extra_bits),
        .table_select (table_select),
        .quant_pos    (quant_pos),
        .quant_value  (quant_value),
        .q_full       (q_full),
        .q_push       (q_push),
        .q_cmd        (push_cmd)
    );

    jcre_queue u_queue
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_cmd (push_cmd),
        .full     (q_full),
        .pop      (q_pop),
        .head     (head),
        .empty    (q_empty)
    );

    jcre_back u_back
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .q_empty     (q_empty),
        .q_pop       (q_pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .coefficient (coef_bits),
        .row         (row),
        .col         (col),
        .block_last  (block_last),
        .overrun     (overrun)
    );

    assign coefficient = $signed(coef_bits);

endmodule

/* dv/testbench.sv */
// ============================================================================
// testbench - coefficient run expander check
// Loads both quantization tables, walks a table of directed symbols (DC
// extremes, EOB, ZRL, zero-size runs, overrun at block end, ignored
// component), then sends random well-formed blocks with noise. A local
// model of DC prediction, zero-run expansion and dequantization predicts
// every coefficient; outputs are compared in order as they transfer.
// ============================================================================
module testbench
    import jcre_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    // ------------------------------------------------------------------
    // Run plan
    // ------------------------------------------------------------------
    localparam int PRELOAD_ITEMS = 128;
    localparam int DIR_ROWS      = 25;
    localparam int RANDOM_ITEMS  = 107;
    localparam int RAMP_BLOCKS   = 22;     // Cr blocks with big positive DC steps
    localparam int QUIET_FROM    = PRELOAD_ITEMS + DIR_ROWS + RANDOM_ITEMS - 40;
    localparam int PRESSURE_AT   = PRELOAD_ITEMS + DIR_ROWS + 30;
    localparam int HOLD_CYCLES   = 300;
    localparam int DRAIN_CYCLES  = 20;
    localparam int CYCLE_LIMIT   = 2000000;
    localparam int MAX_REPORTS   = 40;

    localparam logic [1:0] COMP_CB     = 2'd1;
    localparam logic [1:0] COMP_CR     = 2'd2;
    localparam logic       TSEL_LUMA   = 1'b0;
    localparam logic       TSEL_CHROMA = 1'b1;
    localparam logic [7:0] RS_EOB      = 8'h00;
    localparam logic [7:0] RS_ZRL      = 8'hF0;

    // zigzag index to natural (row * 8 + col)
    localparam int ZZ_NATURAL [64] = '{
         0,  1,  8, 16,  9,  2,  3, 10, 17, 24, 32, 25, 18, 11,  4,  5,
        12, 19, 26, 33, 40, 48, 41, 34, 27, 20, 13,  6,  7, 14, 21, 28,
        35, 42, 49, 56, 57, 50, 43, 36, 29, 22, 15, 23, 30, 37, 44, 51,
        58, 59, 52, 45, 38, 31, 39, 46, 53, 60, 61, 54, 47, 55, 62, 63
    };

    typedef struct packed
    {
        logic        kind;
        logic [1:0]  component;
        logic [7:0]  run_size;
        logic [10:0] extra_bits;
        logic        table_select;
        logic [5:0]  quant_pos;
        logic [7:0]  quant_value;
    } sym_item_t;

    typedef struct packed
    {
        logic signed [23:0] coefficient;
        logic [2:0]         row;
        logic [2:0]         col;
        logic               block_last;
        logic               overrun;
    } coef_t;

    typedef struct packed
    {
        sym_item_t item;
        logic      has_fixed;   // single result typed in below
        coef_t     result;
    } dir_row_t;

    localparam coef_t NO_RESULT = '0;

    // Directed stimulus; quant entries written here are the ones that
    // the fixed results lean on.
    localparam dir_row_t DIRECTED [DIR_ROWS] = '{
        // table extremes: value 255 / 1, positions 0 / 63, both tables
        '{'{KIND_QWRITE, COMP_Y,  8'h00, 11'h000, TSEL_LUMA,   6'd0,  8'd255}, 1'b0, NO_RESULT},
        '{'{KIND_QWRITE, COMP_Y,  8'h00, 11'h000, TSEL_CHROMA, 6'd0,  8'd1},   1'b0, NO_RESULT},
        '{'{KIND_QWRITE, COMP_Y,  8'h00, 11'h000, TSEL_LUMA,   6'd63, 8'd255}, 1'b0, NO_RESULT},
        '{'{KIND_QWRITE, COMP_Y,  8'h00, 11'h000, TSEL_CHROMA, 6'd63, 8'd1},   1'b0, NO_RESULT},
        // Y DC +2047 from reset, times 255
        '{'{KIND_SYMBOL, COMP_Y,  8'h0B, 11'h7FF, TSEL_LUMA,   6'd0,  8'd1},   1'b1,
          '{24'sd521985, 3'd0, 3'd0, 1'b0, 1'b0}},
        '{'{KIND_SYMBOL, COMP_Y,  RS_EOB, 11'h000, TSEL_LUMA,  6'd0,  8'd1},   1'b0, NO_RESULT},
        // Cb DC -2047, run nibble ignored
        '{'{KIND_SYMBOL, COMP_CB, 8'hFB, 11'h000, TSEL_LUMA,   6'd0,  8'd1},   1'b1,
          '{-24'sd2047, 3'd0, 3'd0, 1'b0, 1'b0}},
        // size above eleven, ZRL, zero-size run, runs of 15, overrun at 64
        '{'{KIND_SYMBOL, COMP_CB, 8'h0C, 11'h7FF, TSEL_LUMA,   6'd0,  8'd1},   1'b0, NO_RESULT},
        '{'{KIND_SYMBOL, COMP_CB, RS_ZRL, 11'h000, TSEL_LUMA,  6'd0,  8'd1},   1'b0, NO_RESULT},
        '{'{KIND_SYMBOL, COMP_CB, 8'h30, 11'h000, TSEL_LUMA,   6'd0,  8'd1},   1'b0, NO_RESULT},
        '{'{KIND_SYMBOL, COMP_CB, 8'hF1, 11'h001, TSEL_LUMA,   6'd0,  8'd1},   1'b0, NO_RESULT},
        '{'{KIND_SYMBOL, COMP_CB, 8'hF1, 11'h000, TSEL_LUMA,   6'd0,  8'd1},   1'b0, NO_RESULT},
        '{'{KIND_SYMBOL, COMP_CB, 8'hA5, 11'h015, TSEL_LUMA,   6'd0,  8'd1},   1'b0, NO_RESULT},
        // component three: ignored
        '{'{KIND_SYMBOL, COMP_UNUSED, 8'h0B, 11'h7FF, TSEL_LUMA, 6'd0, 8'd1},  1'b0, NO_RESULT},
        // Cr DC +1, chroma step 1
        '{'{KIND_SYMBOL, COMP_CR, 8'h01, 11'h001, TSEL_LUMA,   6'd0,  8'd1},   1'b1,
          '{24'sd1, 3'd0, 3'd0, 1'b0, 1'b0}},
        // walk to a nonzero coefficient at the last position
        '{'{KIND_SYMBOL, COMP_CR, RS_ZRL, 11'h000, TSEL_LUMA,  6'd0,  8'd1},   1'b0, NO_RESULT},
        '{'{KIND_SYMBOL, COMP_CR, RS_ZRL, 11'h000, TSEL_LUMA,  6'd0,  8'd1},   1'b0, NO_RESULT},
        '{'{KIND_SYMBOL, COMP_CR, RS_ZRL, 11'h000, TSEL_LUMA,  6'd0,  8'd1},   1'b0, NO_RESULT},
        '{'{KIND_SYMBOL, COMP_CR, 8'hE1, 11'h001, TSEL_LUMA,   6'd0,  8'd1},   1'b0, NO_RESULT},
        // Y DC +1024 (size 15 read as 11): 3071 * 255
        '{'{KIND_SYMBOL, COMP_Y,  8'h0F, 11'h400, TSEL_LUMA,   6'd0,  8'd1},   1'b1,
          '{24'sd783105, 3'd0, 3'd0, 1'b0, 1'b0}},
        '{'{KIND_SYMBOL, COMP_Y,  8'h3F, 11'h000, TSEL_LUMA,   6'd0,  8'd1},   1'b0, NO_RESULT},
        // bits above size ignored; table write in mid-block
        '{'{KIND_SYMBOL, COMP_Y,  8'h23, 11'h7FB, TSEL_LUMA,   6'd0,  8'd1},   1'b0, NO_RESULT},
        '{'{KIND_QWRITE, COMP_Y,  8'h00, 11'h000, TSEL_LUMA,   6'd9,  8'd200}, 1'b0, NO_RESULT},
        '{'{KIND_SYMBOL, COMP_Y,  8'h11, 11'h001, TSEL_LUMA,   6'd0,  8'd1},   1'b0, NO_RESULT},
        '{'{KIND_SYMBOL, COMP_Y,  RS_EOB, 11'h000, TSEL_LUMA,  6'd0,  8'd1},   1'b0, NO_RESULT}
    };

    // ------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------
    logic               clk          = 1'b0;
    logic               rst_n        = 1'b0;
    logic               in_valid     = 1'b0;
    logic               in_stall;
    logic               kind         = 1'b0;
    logic [1:0]         component    = '0;
    logic [7:0]         run_size     = '0;
    logic [10:0]        extra_bits   = '0;
    logic               table_select = 1'b0;
    logic [5:0]         quant_pos    = '0;
    logic [7:0]         quant_value  = 8'd1;
    logic               out_valid;
    logic               out_stall    = 1'b0;
    logic signed [23:0] coefficient;
    logic [2:0]         row;
    logic [2:0]         col;
    logic               block_last;
    logic               overrun;

    jpeg_coefficient_run_expander dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .component    (component),
        .run_size     (run_size),
        .extra_bits   (extra_bits),
        .table_select (table_select),
        .quant_pos    (quant_pos),
        .quant_value  (quant_value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .coefficient  (coefficient),
        .row          (row),
        .col          (col),
        .block_last   (block_last),
        .overrun      (overrun)
    );

    always #1 clk = ~clk;

    // ------------------------------------------------------------------
    // Decoder state mirror and expected coefficients
    // ------------------------------------------------------------------
    logic [15:0] dc_pred [3]     = '{default: '0};
    logic [7:0]  quant_shadow [128];
    int          blk_pos         = 0;
    coef_t       pending_coefs [$];
    int          items_done      = 0;
    int          err_count       = 0;
    int          cycle_count     = 0;

    // sign-extend JPEG magnitude bits (msb clear means negative)
    function automatic int signed_magnitude(input logic [3:0] size_code,
                                            input logic [10:0] bits);
        int sz;
        int mask;
        int raw;
        sz = (size_code > 4'd11) ? 11 : int'(size_code);
        if (sz == 0)
            return 0;
        mask = (1 << sz) - 1;
        raw  = int'(bits) & mask;
        if (raw[sz-1] == 1'b0)
            return raw - mask;
        return raw;
    endfunction

    function automatic void push_coef(input int value, input int zz, input logic ovr);
        coef_t c;
        int    nat;
        nat           = ZZ_NATURAL[zz];
        c.coefficient = value[23:0];
        c.row         = nat[5:3];
        c.col         = nat[2:0];
        c.block_last  = (zz == BLOCK_COEFFS - 1);
        c.overrun     = ovr;
        pending_coefs.insert(pending_coefs.size(), c);
    endfunction

    // advance the mirror by one accepted transfer, queueing its coefficients
    function automatic void expand_symbol(input sym_item_t it);
        int   mag;
        int   pos;
        int   stop;
        int   prod;
        logic tsel;
        if (it.kind == KIND_QWRITE)
        begin
            quant_shadow[{it.table_select, it.quant_pos}] = it.quant_value;
            return;
        end
        if (it.component == COMP_UNUSED)
            return;
        tsel = (it.component != COMP_Y);
        pos  = blk_pos;
        mag  = signed_magnitude(it.run_size[3:0], it.extra_bits);

        // DC: predictor wraps at 16 bits, run nibble ignored
        if (pos == 0)
        begin
            dc_pred[it.component] = dc_pred[it.component] + mag[15:0];
            prod = int'($signed(dc_pred[it.component])) * int'(quant_shadow[{tsel, 6'd0}]);
            push_coef(prod, 0, 1'b0);
            blk_pos = 1;
            return;
        end

        // end of block: zero fill
        if (it.run_size == RS_EOB)
        begin
            while (pos < BLOCK_COEFFS)
            begin
                push_coef(0, pos, 1'b0);
                pos++;
            end
            blk_pos = 0;
            return;
        end

        // run past block end: truncate, drop the value, flag all results
        stop = pos + int'(it.run_size[7:4]);
        if (stop >= BLOCK_COEFFS)
        begin
            while (pos < BLOCK_COEFFS)
            begin
                push_coef(0, pos, 1'b1);
                pos++;
            end
            blk_pos = 0;
            return;
        end

        while (pos < stop)
        begin
            push_coef(0, pos, 1'b0);
            pos++;
        end
        prod = (mag == 0) ? 0 : mag * int'(quant_shadow[{tsel, 6'(pos)}]);
        push_coef(prod, pos, 1'b0);
        blk_pos = (pos + 1 >= BLOCK_COEFFS) ? 0 : pos + 1;
    endfunction

    function automatic sym_item_t random_fields();
        sym_item_t it;
        it.kind         = 1'($urandom_range(0, 1));
        it.component    = 2'($urandom_range(0, 3));
        it.run_size     = 8'($urandom_range(0, 255));
        it.extra_bits   = 11'($urandom_range(0, 2047));
        it.table_select = 1'($urandom_range(0, 1));
        it.quant_pos    = 6'($urandom_range(0, 63));
        it.quant_value  = 8'($urandom_range(1, 255));
        return it;
    endfunction

    // drive one item at the falling edge, hold it until the transfer
    task automatic send_item(input sym_item_t it);
        int idle_n;
        idle_n = 0;
        if (items_done < QUIET_FROM && $urandom_range(0, 5) == 0)
            idle_n = $urandom_range(1, 15);
        @(negedge clk);
        if (idle_n > 0)
        begin
            in_valid <= 1'b0;
            repeat (idle_n) @(negedge clk);
        end
        in_valid     <= 1'b1;
        kind         <= it.kind;
        component    <= it.component;
        run_size     <= it.run_size;
        extra_bits   <= it.extra_bits;
        table_select <= it.table_select;
        quant_pos    <= it.quant_pos;
        quant_value  <= it.quant_value;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        expand_symbol(it);
        items_done++;
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    initial
    begin : stimulus
        sym_item_t  it;
        int         pick;
        int         random_sent;
        int         dc_seen;
        logic [1:0] blk_comp;

        random_sent = 0;
        dc_seen     = 0;
        blk_comp    = COMP_Y;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // fill both tables so every later read hits a written entry
        for (int i = 0; i < PRELOAD_ITEMS; i++)
        begin
            it              = random_fields();
            it.kind         = KIND_QWRITE;
            it.table_select = i[6];
            it.quant_pos    = i[5:0];
            send_item(it);
        end

        foreach (DIRECTED[i])
        begin
            send_item(DIRECTED[i].item);
            if (DIRECTED[i].has_fixed)
                pending_coefs[pending_coefs.size() - 1] = DIRECTED[i].result;
        end

        // random blocks, with table writes and ignored symbols mixed in
        while (random_sent < RANDOM_ITEMS)
        begin
            it   = random_fields();
            pick = $urandom_range(0, 99);
            if (pick < 7)
            begin
                it.kind = KIND_QWRITE;
            end
            else
            begin
                it.kind = KIND_SYMBOL;
                if (pick < 10)
                begin
                    it.component = COMP_UNUSED;
                end
                else if (blk_pos == 0)
                begin
                    // DC; early Cr blocks climb until the predictor wraps
                    if (dc_seen < RAMP_BLOCKS)
                    begin
                        blk_comp              = COMP_CR;
                        it.run_size[3:0]      = 4'd11;
                        it.extra_bits[10:9]   = 2'b11;
                    end
                    else
                    begin
                        blk_comp = 2'($urandom_range(0, 2));
                        if ($urandom_range(0, 7) != 0)
                            it.run_size[3:0] = 4'($urandom_range(0, 11));
                    end
                    it.component = blk_comp;
                    dc_seen++;
                end
                else
                begin
                    it.component = ($urandom_range(0, 9) == 0) ?
                                   2'($urandom_range(0, 2)) : blk_comp;
                    pick = $urandom_range(0, 99);
                    if (pick < ((dc_seen <= RAMP_BLOCKS) ? 50 : 10))
                        it.run_size = RS_EOB;
                    else if (pick < ((dc_seen <= RAMP_BLOCKS) ? 58 : 18))
                        it.run_size = RS_ZRL;
                    else if (pick < ((dc_seen <= RAMP_BLOCKS) ? 65 : 25))
                        it.run_size = it.run_size;     // anything, may overrun
                    else
                        it.run_size = {4'($urandom_range(0, 3)), 4'($urandom_range(0, 11))};
                end
            end
            send_item(it);
            if (!(it.kind == KIND_SYMBOL && it.component == COMP_UNUSED))
                random_sent++;
        end

        @(negedge clk);
        in_valid <= 1'b0;

        while (pending_coefs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (err_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // ------------------------------------------------------------------
    // Output flow control: random stall bursts, calm stretches, one long
    // hold so the command queue fills and the input stalls
    // ------------------------------------------------------------------
    initial
    begin : out_flow
        int   stall_left;
        int   calm_left;
        logic held;
        stall_left = 0;
        calm_left  = 0;
        held       = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!held && items_done >= PRESSURE_AT)
            begin
                held       = 1'b1;
                stall_left = HOLD_CYCLES;
            end
            else if (items_done >= QUIET_FROM)
            begin
                stall_left = 0;
            end
            else if (stall_left == 0 && calm_left == 0)
            begin
                if ($urandom_range(0, 7) == 0)
                    stall_left = $urandom_range(1, 15);
                else if ($urandom_range(0, 19) == 0)
                    calm_left = $urandom_range(20, 60);
            end
            if (calm_left > 0)
                calm_left--;
            out_stall <= (stall_left > 0);
            if (stall_left > 0)
                stall_left--;
        end
    end

    // ------------------------------------------------------------------
    // Result check on every output transfer
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        coef_t got;
        coef_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got.coefficient = coefficient;
            got.row         = row;
            got.col         = col;
            got.block_last  = block_last;
            got.overrun     = overrun;
            if (pending_coefs.size() == 0)
            begin
                if (err_count < MAX_REPORTS)
                    $display({"%0t: unexpected result: expected none, ",
                              "got coef %0d r%0d c%0d last %0b ovr %0b"},
                             $time, $signed(got.coefficient), got.row, got.col,
                             got.block_last, got.overrun);
                err_count++;
            end
            else
            begin
                want = pending_coefs.pop_front();
                if (got.coefficient !== want.coefficient || got.row !== want.row ||
                    got.col !== want.col || got.block_last !== want.block_last ||
                    got.overrun !== want.overrun)
                begin
                    if (err_count < MAX_REPORTS)
                        $display({"%0t: mismatch: expected coef %0d r%0d c%0d ",
                                  "last %0b ovr %0b, got coef %0d r%0d c%0d ",
                                  "last %0b ovr %0b"},
                                 $time, $signed(want.coefficient), want.row, want.col,
                                 want.block_last, want.overrun,
                                 $signed(got.coefficient), got.row, got.col,
                                 got.block_last, got.overrun);
                    err_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

endmodule

/* sim.f */
hw/rtl/jcre_pkg.sv
hw/rtl/jcre_front.sv
hw/rtl/jcre_queue.sv
hw/rtl/jcre_back.sv
hw/rtl/jpeg_coefficient_run_expander.sv
dv/testbench.sv
